// ----- hw/rtl/ljs_pkg.sv -----
// ljs_pkg: widths, reset values and register indexes for the logarithmic jump sampler.
// No dependencies; imported by logarithmic_jump_sampler_top, ljs_sample_checker and tb.
package ljs_pkg;

    localparam int unsigned Q24_W   = 24;               // u, theta, power in Q0.24
    localparam int unsigned INV_W   = 32;               // reciprocal in Q16.16
    localparam int unsigned PROD_W  = Q24_W + INV_W;    // shared multiplier output
    localparam int unsigned TERM_W  = PROD_W - 15;      // rounded term before clamp
    localparam int unsigned CUM_W   = Q24_W + 1;        // cumulative sum, holds 1.0
    localparam int unsigned DIV_STEPS = PROD_W;         // one quotient bit per cycle
    localparam int unsigned DCNT_W  = $clog2(DIV_STEPS);
    localparam int unsigned JUMP_W  = 8;

    localparam logic [Q24_W-1:0] THETA_RESET = 24'd8388608;
    localparam logic [INV_W-1:0] INV_RESET   = 32'd94548;
    localparam logic [CUM_W-1:0] ONE_Q24     = 25'h100_0000;

    typedef enum logic
    {
        REG_THETA    = 1'b0,
        REG_INV_LOG  = 1'b1
    } cfg_index_t;

endpackage

// ----- hw/rtl/logarithmic_jump_sampler_top.sv -----
// Logarithmic-series jump sampler: inverse-transform search over one shared multiplier
// and a radix-2 divider. Depends on ljs_pkg.
//
// Each word on start/uniform_value/last_sample yields exactly one result word, shown for one
// cycle with result_valid; the receiver cannot stall, so the result registers simply hold the
// word for that cycle. busy stays high for the whole search. Every term of the search costs one
// multiply by the reciprocal, a pass through the bit-serial divider (dividing by k) and one
// accumulate, and each term after the first adds one multiply for the power. A new word can be
// taken in the cycle the result is shown. Configuration words are taken at any time (cfg_ready
// is tied high) but must only be written while busy is low.
module logarithmic_jump_sampler_top #(
    parameter int unsigned MAX_K = 255
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [23:0]                 uniform_value,
    input  logic                        last_sample,
    output logic                        result_valid,
    output logic [7:0]                  jump_size,
    output logic                        saturated,
    output logic                        last_out,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  ljs_pkg::cfg_index_t         cfg_index,
    input  logic [31:0]                 cfg_data
);
    import ljs_pkg::*;

    localparam int unsigned KW = $clog2(MAX_K + 1);
    localparam logic [KW-1:0] MAX_K_W = KW'(MAX_K);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_MUL_TERM,
        ST_DIV,
        ST_ACC,
        ST_MUL_POW
    } state_t;

    state_t              state_reg, state_next;
    logic [Q24_W-1:0]    theta_reg, theta_next;
    logic [INV_W-1:0]    inv_reg, inv_next;
    logic [Q24_W-1:0]    u_reg, u_next;
    logic                last_reg, last_next;
    logic [KW-1:0]       k_reg, k_next;
    logic [Q24_W-1:0]    p_reg, p_next;
    logic [CUM_W-1:0]    c_reg, c_next;
    logic [PROD_W-1:0]   quo_reg, quo_next;
    logic [KW-1:0]       rem_reg, rem_next;
    logic [DCNT_W-1:0]   cnt_reg, cnt_next;
    logic                valid_reg, valid_next;
    logic [JUMP_W-1:0]   jump_reg, jump_next;
    logic                sat_reg, sat_next;
    logic                lastout_reg, lastout_next;

    // shared multiplier
    logic [INV_W-1:0]    mul_b;
    logic [PROD_W-1:0]   mul_p;
    logic [PROD_W-1:0]   pow_rnd;

    // divider step
    logic [KW:0]         rem_sh;
    logic [KW:0]         rem_diff;
    logic                q_bit;

    // accumulate
    logic [PROD_W:0]     term_rnd;
    logic [TERM_W-1:0]   term;
    logic [CUM_W:0]      c_sum;
    logic [CUM_W-1:0]    c_acc;
    logic [16:0]         k_wide;

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign result_valid = valid_reg;
    assign jump_size    = jump_reg;
    assign saturated    = sat_reg;
    assign last_out     = lastout_reg;

    assign mul_b   = (state_reg == ST_MUL_POW) ? INV_W'(theta_reg) : inv_reg;
    assign mul_p   = PROD_W'(p_reg) * PROD_W'(mul_b);
    assign pow_rnd = mul_p + PROD_W'(24'h80_0000);

    assign rem_sh   = {rem_reg, quo_reg[PROD_W-1]};
    assign rem_diff = rem_sh - {1'b0, k_reg};
    assign q_bit    = (rem_sh >= {1'b0, k_reg});

    // term = (quotient + 2^15) >> 16, then saturating add at 1.0
    assign term_rnd = {1'b0, quo_reg} + (PROD_W+1)'(17'h0_8000);
    assign term     = term_rnd[PROD_W:16];
    assign c_sum    = {1'b0, c_reg} + (CUM_W+1)'(term[Q24_W-1:0]);
    assign c_acc    = ((|term[TERM_W-1:Q24_W]) || (c_sum >= (CUM_W+1)'(ONE_Q24)))
                      ? ONE_Q24 : c_sum[CUM_W-1:0];
    assign k_wide   = 17'(k_reg);

    always_comb
    begin
        state_next   = state_reg;
        theta_next   = theta_reg;
        inv_next     = inv_reg;
        u_next       = u_reg;
        last_next    = last_reg;
        k_next       = k_reg;
        p_next       = p_reg;
        c_next       = c_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        valid_next   = 1'b0;
        jump_next    = jump_reg;
        sat_next     = sat_reg;
        lastout_next = lastout_reg;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_THETA:   theta_next = cfg_data[Q24_W-1:0];
                REG_INV_LOG: inv_next   = cfg_data;
                default:     ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    u_next     = uniform_value;
                    last_next  = last_sample;
                    k_next     = KW'(1);
                    p_next     = theta_reg;
                    c_next     = '0;
                    state_next = ST_MUL_TERM;
                end
            end
            ST_MUL_TERM:
            begin
                quo_next   = mul_p;
                rem_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next = q_bit ? rem_diff[KW-1:0] : rem_sh[KW-1:0];
                quo_next = {quo_reg[PROD_W-2:0], q_bit};
                cnt_next = cnt_reg + DCNT_W'(1);
                if (cnt_reg == DCNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                c_next = c_acc;
                if ((CUM_W'(u_reg) > c_acc) && (k_reg < MAX_K_W))
                begin
                    k_next     = k_reg + KW'(1);
                    state_next = ST_MUL_POW;
                end
                else
                begin
                    valid_next   = 1'b1;
                    sat_next     = (CUM_W'(u_reg) > c_acc);
                    jump_next    = (k_wide > 17'd255) ? 8'hFF : k_wide[7:0];
                    lastout_next = last_reg;
                    state_next   = ST_IDLE;
                end
            end
            ST_MUL_POW:
            begin
                p_next     = pow_rnd[47:24];
                state_next = ST_MUL_TERM;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            theta_reg   <= THETA_RESET;
            inv_reg     <= INV_RESET;
            u_reg       <= '0;
            last_reg    <= 1'b0;
            k_reg       <= '0;
            p_reg       <= '0;
            c_reg       <= '0;
            quo_reg     <= '0;
            rem_reg     <= '0;
            cnt_reg     <= '0;
            valid_reg   <= 1'b0;
            jump_reg    <= '0;
            sat_reg     <= 1'b0;
            lastout_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            theta_reg   <= theta_next;
            inv_reg     <= inv_next;
            u_reg       <= u_next;
            last_reg    <= last_next;
            k_reg       <= k_next;
            p_reg       <= p_next;
            c_reg       <= c_next;
            quo_reg     <= quo_next;
            rem_reg     <= rem_next;
            cnt_reg     <= cnt_next;
            valid_reg   <= valid_next;
            jump_reg    <= jump_next;
            sat_reg     <= sat_next;
            lastout_reg <= lastout_next;
        end
    end

endmodule

// ----- verif/ljs_sample_checker.sv -----
// ljs_sample_checker: shadows the sampler's registers, predicts each jump word and compares
// results in order. Depends on ljs_pkg; instantiated beside the block by tb.
module ljs_sample_checker
    import ljs_pkg::*;
#(
    parameter int unsigned MAX_K = 255
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [23:0] uniform_value,
    input  logic        last_sample,
    input  logic        result_valid,
    input  logic [7:0]  jump_size,
    input  logic        saturated,
    input  logic        last_out,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  cfg_index_t  cfg_index,
    input  logic [31:0] cfg_data,
    output int          mismatches,
    output int          outstanding,
    output int          checked,
    output int          sat_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [23:0] u;
        logic [7:0]  jump;
        logic        sat;
        logic        last;
    } jump_word_t;

    localparam logic [63:0] CUM_ONE = 64'(ONE_Q24);

    logic [23:0] theta_q;
    logic [31:0] inv_q;
    jump_word_t  pending_jumps[$];

    // Inverse-transform search: running power, term divided by k, cumulative sum capped at 1.0
    function automatic jump_word_t jump_search(input logic [23:0] u, input logic last,
                                               input logic [23:0] theta, input logic [31:0] inv);
        jump_word_t  w;
        logic [63:0] pwr;
        logic [63:0] term;
        logic [63:0] cum;
        int unsigned k;
        w.u    = u;
        w.last = last;
        w.sat  = 1'b0;
        pwr    = 64'(theta);
        cum    = '0;
        k      = 0;
        forever
        begin
            k++;
            if (k > 1)
                pwr = (pwr * 64'(theta) + 64'd8388608) >> 24;
            term = ((pwr * 64'(inv)) / 64'(k) + 64'd32768) >> 16;
            cum  = (term >= CUM_ONE || cum + term >= CUM_ONE) ? CUM_ONE : cum + term;
            if (64'(u) <= cum)
                break;
            if (k >= MAX_K)
            begin
                w.sat = 1'b1;
                break;
            end
        end
        w.jump = (k > 255) ? 8'd255 : 8'(k);
        return w;
    endfunction

    task automatic flag(input string what, input logic [31:0] want, input logic [31:0] seen);
        mismatches++;
        if (mismatches <= 20)
            $display("%0t: %s expected %0d, actual %0d", $time, what, want, seen);
    endtask

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
        checked     = 0;
        sat_seen    = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            theta_q <= THETA_RESET;
            inv_q   <= INV_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_THETA:   theta_q <= cfg_data[23:0];
                REG_INV_LOG: inv_q   <= cfg_data;
                default:     ;
            endcase
        end
    end

    always @(posedge clk)
    begin : watch
        jump_word_t want;
        if (rst_n)
        begin
            if (result_valid)
            begin
                if (pending_jumps.size() == 0)
                    flag("result word with nothing pending, jump_size", 32'd0, 32'(jump_size));
                else
                begin
                    want = pending_jumps.pop_front();
                    checked++;
                    if (want.sat)
                        sat_seen++;
                    if (jump_size !== want.jump)
                        flag($sformatf("u=%06h jump_size", want.u), 32'(want.jump),
                             32'(jump_size));
                    if (saturated !== want.sat)
                        flag($sformatf("u=%06h saturated", want.u), 32'(want.sat),
                             32'(saturated));
                    if (last_out !== want.last)
                        flag($sformatf("u=%06h last_out", want.u), 32'(want.last),
                             32'(last_out));
                end
            end
            if (start && !busy)
                pending_jumps.push_back(jump_search(uniform_value, last_sample, theta_q, inv_q));
            outstanding = pending_jumps.size();
        end
    end

endmodule

// ----- verif/tb.sv -----
// tb: drives samples and register writes into logarithmic_jump_sampler_top and gives the verdict.
// Depends on ljs_pkg, logarithmic_jump_sampler_top and ljs_sample_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ljs_pkg::*;

    localparam int unsigned SEARCH_LIMIT    = 255;
    localparam int          WATCHDOG_CYCLES = 60000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [23:0] uniform_value;
    logic        last_sample;
    logic        result_valid;
    logic [7:0]  jump_size;
    logic        saturated;
    logic        last_out;
    logic        cfg_valid;
    logic        cfg_ready;
    cfg_index_t  cfg_index;
    logic [31:0] cfg_data;

    int mismatches;
    int outstanding;
    int checked;
    int sat_seen;
    int burst_left    = 0;
    int items_sent    = 0;
    int settings_used = 1;
    int idle_cycles   = 0;

    logarithmic_jump_sampler_top #(.MAX_K(SEARCH_LIMIT)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .uniform_value(uniform_value),
        .last_sample  (last_sample),
        .result_valid (result_valid),
        .jump_size    (jump_size),
        .saturated    (saturated),
        .last_out     (last_out),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    ljs_sample_checker #(.MAX_K(SEARCH_LIMIT)) chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .uniform_value(uniform_value),
        .last_sample  (last_sample),
        .result_valid (result_valid),
        .jump_size    (jump_size),
        .saturated    (saturated),
        .last_out     (last_out),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .checked      (checked),
        .sat_seen     (sat_seen)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // a search that runs to the jump limit is the longest wait; anything far beyond that is a hang
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_CYCLES)
        begin
            $display("Timeout after %0d idle cycles, %0d words pending", idle_cycles, outstanding);
            $display("Some tests failed");
            $finish;
        end
    end

    // start may rise while busy is high, so the hold-off lands anywhere in the search
    task automatic send_sample(input logic [23:0] u, input logic last);
        logic idle_now;
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            if ($urandom_range(0, 3) != 0)
                repeat ($urandom_range(1, 150)) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        start         <= 1'b1;
        uniform_value <= u;
        last_sample   <= last;
        do
        begin
            idle_now = !busy;
            @(negedge clk);
        end
        while (!idle_now);
        start <= 1'b0;
        items_sent++;
    endtask

    task automatic random_samples(input int count, input logic [23:0] umax);
        repeat (count)
            send_sample(24'($urandom_range(0, umax)), $urandom_range(0, 5) == 0);
    endtask

    task automatic pause_until_drained();
        @(negedge clk);
        while (outstanding != 0 || busy)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [31:0] value);
        logic ready_now;
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
        begin
            ready_now = cfg_ready;
            @(negedge clk);
        end
        while (!ready_now);
        cfg_valid <= 1'b0;
    endtask

    // upper data bits of a theta write are junk on purpose: only 24 bits are kept
    task automatic load_settings(input logic [23:0] theta, input logic [31:0] inv);
        pause_until_drained();
        write_reg(REG_THETA, {8'($urandom), theta});
        write_reg(REG_INV_LOG, inv);
        settings_used++;
    endtask

    initial
    begin
        logic [23:0] theta_pick;
        real         ln_term;
        start         = 1'b0;
        uniform_value = '0;
        last_sample   = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_THETA;
        cfg_data      = '0;
        rst_n         = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: field extremes, bit patterns, and both sides of the first step
        send_sample(24'h000000, 1'b0);
        send_sample(24'hFFFFFF, 1'b1);
        send_sample(24'd12102144, 1'b0);
        send_sample(24'd12102145, 1'b1);
        send_sample(24'hAAAAAA, 1'b0);
        send_sample(24'h555555, 1'b1);
        send_sample(24'h000001, 1'b0);
        send_sample(24'h800000, 1'b1);
        random_samples(500, 24'hFFFFFF);

        load_settings(24'd1677722, 32'd622018);      // theta 0.1
        random_samples(300, 24'hFFFFFF);
        load_settings(24'd15099494, 32'd28462);      // theta 0.9, longer tail
        random_samples(250, 24'hFFFFFF);
        load_settings(THETA_RESET, 32'hFFFF_FFFF);   // first term already at 1.0
        random_samples(150, 24'hFFFFFF);

        repeat (6)
        begin
            theta_pick = 24'($urandom_range(512, 15938355));
            ln_term    = -$ln(1.0 - real'(theta_pick) / 16777216.0);
            load_settings(theta_pick, 32'(longint'(65536.0 / ln_term)));
            random_samples(110, 24'hFFFFFF);
        end

        // theta just under one: the cumulative sum stays low, so most full-range draws run to the limit
        load_settings(24'hFFFFFF, 32'd3939);
        random_samples(6, 24'd3000);
        random_samples(2, 24'hFFFFFF);

        // smallest theta and reciprocal: every term rounds to zero
        load_settings(24'd1, 32'd1);
        repeat (4) send_sample(24'h000000, 1'($urandom_range(0, 1)));
        random_samples(2, 24'hFFFFFF);

        // power vanishes after the first term
        load_settings(24'd1, 32'hFFFF_FFFF);
        random_samples(4, 24'd70000);
        random_samples(2, 24'hFFFFFF);

        load_settings(24'd0, INV_RESET);
        repeat (3) send_sample(24'h000000, 1'($urandom_range(0, 1)));
        random_samples(2, 24'hFFFFFF);

        load_settings(THETA_RESET, 32'd0);
        repeat (3) send_sample(24'h000000, 1'($urandom_range(0, 1)));
        random_samples(2, 24'hFFFFFF);

        load_settings(THETA_RESET, INV_RESET);
        random_samples(60, 24'hFFFFFF);

        pause_until_drained();
        repeat (100) @(negedge clk);
        $display("Sent %0d samples across %0d register settings; %0d words checked.",
                 items_sent, settings_used, checked);
        $display("%0d searches stopped at the jump limit of %0d.", sat_seen, SEARCH_LIMIT);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
